// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// Stitch path statistics package
// Shared widths, word types, register indexes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    // Internal count width and coordinate width.
    localparam int COUNT_BITS = 20;
    localparam int COORD_BITS = 24;

    // Fixed field widths of the words.
    localparam int POS_BITS     = 24;
    localparam int FLAG_BITS    = 8;
    localparam int CNT_OUT_BITS = 20;
    localparam int SUM_BITS     = 40;
    localparam int LEN_BITS     = 25;

    // Square root sizing: the squared distance is below 2^(2*COORD_BITS+1).
    localparam int PROD_BITS     = 2 * COORD_BITS;
    localparam int ROOT_BITS     = COORD_BITS + 1;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int ROOT_EXT_BITS = (ROOT_BITS > LEN_BITS) ? ROOT_BITS : LEN_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

    // Configuration port.
    localparam int CFG_INDEX_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_CODE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_JUMP_MASK   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIM_MASK   = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_MASK    = CFG_INDEX_BITS'(3);

    localparam logic [FLAG_BITS-1:0] NORMAL_CODE_RESET = 8'd0;
    localparam logic [FLAG_BITS-1:0] JUMP_MASK_RESET   = 8'd1;
    localparam logic [FLAG_BITS-1:0] TRIM_MASK_RESET   = 8'd2;
    localparam logic [FLAG_BITS-1:0] END_MASK_RESET    = 8'd16;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [FLAG_BITS-1:0] normal_code;
        logic [FLAG_BITS-1:0] jump_mask;
        logic [FLAG_BITS-1:0] trim_mask;
        logic [FLAG_BITS-1:0] end_mask;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic [FLAG_BITS-1:0]       stitch_flags;
        logic                       last_stitch;
    } in_word_t;

    typedef struct packed {
        logic [CNT_OUT_BITS-1:0] stitch_total;
        logic [CNT_OUT_BITS-1:0] real_total;
        logic [CNT_OUT_BITS-1:0] jump_total;
        logic [CNT_OUT_BITS-1:0] trim_total;
        logic [SUM_BITS-1:0]     thread_length;
        logic [LEN_BITS-1:0]     shortest_length;
        logic [LEN_BITS-1:0]     longest_length;
    } out_word_t;

    // Control from the sequencer to the statistics registers.
    typedef struct packed {
        logic                 update;
        logic                 clear;
        logic                 had_prev;
        logic [FLAG_BITS-1:0] flags;
        logic [FLAG_BITS-1:0] prev_flags;
    } stats_ctl_t;

    // The low COORD_BITS of a position, as two's complement.
    function automatic coord_t to_coord(input logic signed [POS_BITS-1:0] v);
        return COORD_BITS'(v);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sps_dist.sv =====
// ----------------------------------------------------------------------------
// Stitch distance unit
// Absolute differences, one shared multiplier for both squares, then a
// bit-serial floor square root that resolves one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_dist
    import sps_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire coord_t              cur_x,
    input  wire coord_t              cur_y,
    input  wire coord_t              prev_x,
    input  wire coord_t              prev_y,
    output logic                     done,
    output logic [LEN_BITS-1:0]      len
);

    localparam int CNT_BITS = $clog2(ROOT_BITS);

    typedef enum logic [2:0] {
        D_IDLE,
        D_MX,
        D_MY,
        D_ADD,
        D_ROOT,
        D_DONE
    } dist_state_t;

    dist_state_t               state_reg;
    logic [COORD_BITS-1:0]     dx_reg;
    logic [COORD_BITS-1:0]     dy_reg;
    logic [PROD_BITS-1:0]      prod_reg;
    logic [PROD_BITS-1:0]      acc_reg;
    logic [RAD_BITS-1:0]       rad_reg;
    logic [ROOT_BITS+1:0]      rem_reg;
    logic [ROOT_BITS-1:0]      root_reg;
    logic [CNT_BITS-1:0]       cnt_reg;

    logic signed [COORD_BITS:0] dx_ab, dx_ba, dy_ab, dy_ba;
    logic [COORD_BITS-1:0]      dx_mag, dy_mag;
    logic [COORD_BITS-1:0]      mul_a;
    logic [PROD_BITS-1:0]       product;
    logic [ROOT_BITS+1:0]       rem_sh;
    logic [ROOT_BITS+1:0]       trial;
    logic                       take;
    logic [ROOT_EXT_BITS-1:0]   root_ext;

    // Both subtraction orders in parallel; the sign of one picks the magnitude.
    assign dx_ab  = {cur_x[COORD_BITS-1], cur_x} - {prev_x[COORD_BITS-1], prev_x};
    assign dx_ba  = {prev_x[COORD_BITS-1], prev_x} - {cur_x[COORD_BITS-1], cur_x};
    assign dy_ab  = {cur_y[COORD_BITS-1], cur_y} - {prev_y[COORD_BITS-1], prev_y};
    assign dy_ba  = {prev_y[COORD_BITS-1], prev_y} - {cur_y[COORD_BITS-1], cur_y};
    assign dx_mag = dx_ab[COORD_BITS] ? dx_ba[COORD_BITS-1:0] : dx_ab[COORD_BITS-1:0];
    assign dy_mag = dy_ab[COORD_BITS] ? dy_ba[COORD_BITS-1:0] : dy_ab[COORD_BITS-1:0];

    assign mul_a   = (state_reg == D_MX) ? dx_reg : dy_reg;
    assign product = PROD_BITS'(mul_a) * PROD_BITS'(mul_a);

    // One step of the restoring square root: bring in two radicand bits.
    assign rem_sh = {rem_reg[ROOT_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    assign root_ext = ROOT_EXT_BITS'(root_reg);
    assign len      = (root_ext > ROOT_EXT_BITS'(LEN_MAX)) ? LEN_MAX
                                                          : root_ext[LEN_BITS-1:0];
    assign done     = (state_reg == D_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg    <= dx_mag;
                        dy_reg    <= dy_mag;
                        state_reg <= D_MX;
                    end
                end
                D_MX:
                begin
                    prod_reg  <= product;
                    state_reg <= D_MY;
                end
                D_MY:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= product;
                    state_reg <= D_ADD;
                end
                D_ADD:
                begin
                    rad_reg   <= RAD_BITS'(acc_reg) + RAD_BITS'(prod_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= D_ROOT;
                end
                D_ROOT:
                begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= take ? rem_sh - trial : rem_sh;
                    root_reg <= {root_reg[ROOT_BITS-2:0], take};
                    cnt_reg  <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sps_stats.sv =====
// ----------------------------------------------------------------------------
// Stitch statistics registers
// Saturating stitch counts, thread length sum and the shortest and longest
// normal-to-normal lengths of the current pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_stats
    import sps_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire stats_ctl_t          ctl,
    input  wire logic [LEN_BITS-1:0] len,
    output out_word_t                stats
);

    logic [COUNT_BITS-1:0] all_reg,  all_next;
    logic [COUNT_BITS-1:0] real_reg, real_next;
    logic [COUNT_BITS-1:0] jump_reg, jump_next;
    logic [COUNT_BITS-1:0] trim_reg, trim_next;
    logic [SUM_BITS-1:0]   sum_reg,  sum_next;
    logic [LEN_BITS-1:0]   min_reg,  min_next;
    logic [LEN_BITS-1:0]   max_reg,  max_next;

    logic [SUM_BITS:0] sum_ext;
    logic              is_normal;
    logic              is_pair;

    assign sum_ext   = {1'b0, sum_reg} + (SUM_BITS + 1)'(len);
    assign is_normal = ctl.had_prev && (ctl.flags == cfg.normal_code);
    assign is_pair   = is_normal && (ctl.prev_flags == cfg.normal_code);

    always_comb
    begin
        all_next  = all_reg;
        real_next = real_reg;
        jump_next = jump_reg;
        trim_next = trim_reg;
        sum_next  = sum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (ctl.clear)
        begin
            all_next  = '0;
            real_next = '0;
            jump_next = '0;
            trim_next = '0;
            sum_next  = '0;
            min_next  = LEN_MAX;
            max_next  = '0;
        end
        else if (ctl.update)
        begin
            all_next = sat_inc(all_reg);
            if ((ctl.flags & (cfg.jump_mask | cfg.trim_mask | cfg.end_mask)) == '0)
            begin
                real_next = sat_inc(real_reg);
            end
            if ((ctl.flags & cfg.jump_mask) != '0)
            begin
                jump_next = sat_inc(jump_reg);
            end
            if ((ctl.flags & cfg.trim_mask) != '0)
            begin
                trim_next = sat_inc(trim_reg);
            end
            if (is_normal)
            begin
                sum_next = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
            end
            if (is_pair && (len < min_reg))
            begin
                min_next = len;
            end
            if (is_pair && (len > max_reg))
            begin
                max_next = len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_reg  <= '0;
            real_reg <= '0;
            jump_reg <= '0;
            trim_reg <= '0;
            sum_reg  <= '0;
            min_reg  <= LEN_MAX;
            max_reg  <= '0;
        end
        else
        begin
            all_reg  <= all_next;
            real_reg <= real_next;
            jump_reg <= jump_next;
            trim_reg <= trim_next;
            sum_reg  <= sum_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

    assign stats.stitch_total    = CNT_OUT_BITS'(all_reg);
    assign stats.real_total      = CNT_OUT_BITS'(real_reg);
    assign stats.jump_total      = CNT_OUT_BITS'(jump_reg);
    assign stats.trim_total      = CNT_OUT_BITS'(trim_reg);
    assign stats.thread_length   = sum_reg;
    assign stats.shortest_length = min_reg;
    assign stats.longest_length  = max_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stitch_path_statistics.sv =====
// ----------------------------------------------------------------------------
// Stitch path statistics
// Walks a stream of stitches and reports counts and thread lengths at the
// end of each pattern.
// ----------------------------------------------------------------------------
// Usage. Stitch words arrive on in_valid / in_ready / in_word; one statistics
// word leaves on out_valid / out_ready / out_word for each stitch that has
// last_stitch set. The user writes registers through cfg_we / cfg_index /
// cfg_wdata, one write per cycle, while idle; the block does not enforce it.
// Flow. One stitch is taken at a time and in_ready stays low while it
// is worked on. The first stitch of a pattern goes through accept and
// update only; every later stitch also passes the distance unit, whose
// bit-serial square root, one root bit per cycle, is its longest step;
// the squares share a single multiplier ahead of it. The last stitch
// then loads the result into the output register.
// Result. out_valid rises once a closing stitch has been updated and its
// result loaded; the load waits while the output register is still full.
// Stalls. The result sits in an output register and further stitches are
// accepted while it waits; only a following last stitch holds until the
// previous result has been taken.
// Reset. rst_n clears all counts and the previous stitch, sets the
// registers to their defaults and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stitch_path_statistics
    import sps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [FLAG_BITS-1:0]      cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_word_t                  in_word,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output out_word_t                      out_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIST,
        ST_UPDATE,
        ST_EMIT
    } seq_state_t;

    seq_state_t           state_reg,      state_next;
    cfg_t                 cfg_reg;
    logic [FLAG_BITS-1:0] flags_reg,      flags_next;
    logic                 last_reg,       last_next;
    coord_t               cur_x_reg,      cur_x_next;
    coord_t               cur_y_reg,      cur_y_next;
    coord_t               prev_x_reg,     prev_x_next;
    coord_t               prev_y_reg,     prev_y_next;
    logic [FLAG_BITS-1:0] prev_flags_reg, prev_flags_next;
    logic                 have_prev_reg,  have_prev_next;
    logic                 had_prev_reg,   had_prev_next;
    logic                 out_valid_reg,  out_valid_next;
    out_word_t            out_word_reg,   out_word_next;

    logic                 in_fire;
    logic                 emit_fire;
    logic                 dist_done;
    logic [LEN_BITS-1:0]  dist_len;
    stats_ctl_t           stats_ctl;
    out_word_t            stats;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Registers take the whole 8-bit write data; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_code <= NORMAL_CODE_RESET;
            cfg_reg.jump_mask   <= JUMP_MASK_RESET;
            cfg_reg.trim_mask   <= TRIM_MASK_RESET;
            cfg_reg.end_mask    <= END_MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NORMAL_CODE: cfg_reg.normal_code <= cfg_wdata;
                REG_JUMP_MASK:   cfg_reg.jump_mask   <= cfg_wdata;
                REG_TRIM_MASK:   cfg_reg.trim_mask   <= cfg_wdata;
                REG_END_MASK:    cfg_reg.end_mask    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // The distance is measured from the previous stitch to the one arriving.
    sps_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire && have_prev_reg),
        .cur_x  (to_coord(in_word.pos_x)),
        .cur_y  (to_coord(in_word.pos_y)),
        .prev_x (prev_x_reg),
        .prev_y (prev_y_reg),
        .done   (dist_done),
        .len    (dist_len)
    );

    assign stats_ctl.update     = (state_reg == ST_UPDATE);
    assign stats_ctl.clear      = emit_fire;
    assign stats_ctl.had_prev   = had_prev_reg;
    assign stats_ctl.flags      = flags_reg;
    assign stats_ctl.prev_flags = prev_flags_reg;

    sps_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (stats_ctl),
        .len   (dist_len),
        .stats (stats)
    );

    always_comb
    begin
        state_next      = state_reg;
        flags_next      = flags_reg;
        last_next       = last_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_flags_next = prev_flags_reg;
        have_prev_next  = have_prev_reg;
        had_prev_next   = had_prev_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    flags_next    = in_word.stitch_flags;
                    last_next     = in_word.last_stitch;
                    cur_x_next    = to_coord(in_word.pos_x);
                    cur_y_next    = to_coord(in_word.pos_y);
                    had_prev_next = have_prev_reg;
                    state_next    = have_prev_reg ? ST_DIST : ST_UPDATE;
                end
            end
            ST_DIST:
            begin
                if (dist_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                prev_x_next     = cur_x_reg;
                prev_y_next     = cur_y_reg;
                prev_flags_next = flags_reg;
                have_prev_next  = 1'b1;
                state_next      = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = stats;
                    // A pattern of a single stitch has no lengths at all.
                    if (!had_prev_reg)
                    begin
                        out_word_next.thread_length   = '0;
                        out_word_next.shortest_length = '0;
                        out_word_next.longest_length  = '0;
                    end
                    prev_x_next     = '0;
                    prev_y_next     = '0;
                    prev_flags_next = '0;
                    have_prev_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_flags_reg <= '0;
            have_prev_reg  <= 1'b0;
            had_prev_reg   <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_flags_reg <= prev_flags_next;
            have_prev_reg  <= have_prev_next;
            had_prev_reg   <= had_prev_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg    <= flags_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        out_word_reg <= out_word_next;
    end

`ifndef ASSERT_OFF
    // The distance unit only finishes while the sequencer waits for it.
    a_done_in_dist: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == ST_DIST))
        else $error("distance finished outside the wait state");

    // A stitch that follows another must go through the distance unit.
    a_dist_after_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && have_prev_reg) |=> (state_reg == ST_DIST))
        else $error("stitch with a predecessor skipped the distance unit");

    // Loading a result clears the pattern so the next stitch starts afresh.
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (!have_prev_reg && out_valid_reg && in_ready))
        else $error("pattern state not cleared after result");
`endif

endmodule

`default_nettype wire
